### hdl/ffms_pkg.sv
package ffms_pkg;

	// input operand and accumulator widths
	localparam int IN_W   = 32;
	localparam int N_OPS  = 8;
	localparam int ACC_W  = 66;
	localparam int MAG_W  = 65;
	localparam int DISC_W = 2 * MAG_W + 1;

	// root word, infinity is all ones
	localparam int ROOT_W = 48;
	localparam logic [ROOT_W-1:0] ROOT_INF = '1;

	// configuration registers
	localparam int FRAC_W = 17;
	localparam int LIM_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_FRACTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_CAP      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO     = 2'd2;
	localparam logic [FRAC_W-1:0] STEP_FRACTION_RST = 17'd52429;
	localparam logic [FRAC_W-1:0] STEP_CAP_RST      = 17'd65536;
	localparam logic [LIM_W-1:0]  NEAR_ZERO_RST     = 32'd0;

	// default fraction bits of the root
	localparam int FRAC_BITS_DEF = 16;

	// queue between front and back
	localparam int QDEPTH = 2;

	// output word
	localparam int OUT_W = 24;

	// one classified triangle: det(E + tD) = a t^2 + b t + c
	typedef struct packed {
		logic signed [ACC_W-1:0] a;
		logic signed [ACC_W-1:0] b;
		logic signed [ACC_W-1:0] c;
		logic                    quad;
		logic                    last;
	} ffms_job_t;

	// magnitude of a signed accumulator value
	function automatic logic [MAG_W-1:0] mag(input logic signed [ACC_W-1:0] x);
		logic [ACC_W-1:0] t;
		t = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
		return t[MAG_W-1:0];
	endfunction

endpackage

### hdl/flip_free_max_step_core.sv
// Flip-avoiding maximum step of a 2D triangle layout.
// s_t* channel: one triangle a word, eight signed Q16.16 edge and move
// vectors in s_tdata, s_tlast marks the final triangle of the mesh.
// m_t* channel: one word per mesh, after the triangle with s_tlast,
// step_size in Q1.16 on m_tdata and root_found on m_tuser.
// cfg_* channel: register writes, always ready; index 0 step_fraction,
// 1 step_cap, 2 near_zero_limit. Write only while the block is idle.
// The front forms eight products on one 32x32 multiplier and takes a new
// triangle only once the last is pushed; a two-entry queue sits between
// front and back. The back sets the rate: a quadratic triangle runs a
// serial 65-bit multiply for b*b and a*c, then a bit-serial square root
// and restoring divide, skipping both if its discriminant is negative;
// a linear one runs only the divide, a linear one with no root neither.
// After the last root the result word passes the update, product and
// emit states and waits in an output register while m_tready is low;
// the back stalls only if a second result is due before it is taken.
// Reset clears the queue, the running minimum (to infinity) and the
// registers to 0.8, 1.0 and 0.
module flip_free_max_step_core #(
	parameter int FRAC_BITS = ffms_pkg::FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// edge1_x, edge1_y, edge2_x, edge2_y, move1_x, move1_y, move2_x, move2_y
	input  logic [ffms_pkg::IN_W*ffms_pkg::N_OPS-1:0] s_tdata,
	input  logic                                      s_tlast,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// step_size, zero fill
	output logic [ffms_pkg::OUT_W-1:0]                m_tdata,
	// root_found
	output logic [0:0]                                m_tuser,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [ffms_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [ffms_pkg::LIM_W-1:0]                cfg_data
);
	import ffms_pkg::*;

	logic [FRAC_W-1:0] step_fraction_q, step_cap_q;
	logic [LIM_W-1:0] near_zero_q;
	ffms_job_t push_job, pop_job;
	logic push_valid, q_full, q_empty, q_pop;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_fraction_q <= STEP_FRACTION_RST;
			step_cap_q      <= STEP_CAP_RST;
			near_zero_q     <= NEAR_ZERO_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STEP_FRACTION: step_fraction_q <= cfg_data[FRAC_W-1:0];
				REG_STEP_CAP:      step_cap_q      <= cfg_data[FRAC_W-1:0];
				REG_NEAR_ZERO:     near_zero_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficient front
	ffms_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.near_zero_limit (near_zero_q),
		.job             (push_job),
		.job_valid       (push_valid),
		.job_full        (q_full)
	);

	// decoupling queue
	ffms_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push_valid && !q_full),
		.wdata  (push_job),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (pop_job)
	);

	// root solver and minimum
	ffms_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (pop_job),
		.job_empty     (q_empty),
		.job_pop       (q_pop),
		.step_fraction (step_fraction_q),
		.step_cap      (step_cap_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

endmodule

### hdl/ffms_front.sv
module ffms_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [ffms_pkg::IN_W*ffms_pkg::N_OPS-1:0] s_tdata,
	input  logic                                  s_tlast,
	input  logic [ffms_pkg::LIM_W-1:0]            near_zero_limit,
	output ffms_pkg::ffms_job_t                   job,
	output logic                                  job_valid,
	input  logic                                  job_full
);
	import ffms_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_FIN  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0] state_q;
	logic [2:0] cnt_q;
	logic [IN_W*N_OPS-1:0] vec_q;
	logic last_q;
	logic signed [ACC_W-1:0] a_q, b_q, c_q;
	logic signed [2*IN_W-1:0] prod_s1;
	logic [2:0] tag_s1;
	logic pv_s1;

	logic signed [IN_W-1:0] v [N_OPS];
	logic signed [IN_W-1:0] op_x, op_y;
	logic signed [ACC_W-1:0] prod_ext, term;
	logic [MAG_W-1:0] a_mag;

	// unpack operands
	always_comb begin
		for (int i = 0; i < N_OPS; i++) begin
			v[i] = vec_q[i*IN_W +: IN_W];
		end
	end

	// product schedule: a terms, c terms, then the four mixed terms of b
	always_comb begin
		case (cnt_q)
			3'd0: begin op_x = v[4]; op_y = v[7]; end
			3'd1: begin op_x = v[6]; op_y = v[5]; end
			3'd2: begin op_x = v[0]; op_y = v[3]; end
			3'd3: begin op_x = v[2]; op_y = v[1]; end
			3'd4: begin op_x = v[0]; op_y = v[7]; end
			3'd5: begin op_x = v[2]; op_y = v[5]; end
			3'd6: begin op_x = v[4]; op_y = v[3]; end
			default: begin op_x = v[6]; op_y = v[1]; end
		endcase
	end

	// odd tags are subtracted
	assign prod_ext = ACC_W'(prod_s1);
	assign term     = tag_s1[0] ? ACC_W'(-prod_ext) : prod_ext;

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_s1 <= op_x * op_y;
		tag_s1  <= cnt_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			pv_s1   <= 1'b0;
		end else begin
			pv_s1 <= (state_q == F_MUL);
			unique case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= '0;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= F_FIN;
					end
				end
				F_FIN: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!job_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// operand capture and accumulation
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && s_tvalid) begin
			vec_q  <= s_tdata;
			last_q <= s_tlast;
			a_q    <= '0;
			b_q    <= '0;
			c_q    <= '0;
		end else if (pv_s1) begin
			case (tag_s1[2:1])
				2'd0:    a_q <= a_q + term;
				2'd1:    c_q <= c_q + term;
				default: b_q <= b_q + term;
			endcase
		end
	end

	// classify quadratic against the near-zero limit
	assign a_mag = mag(a_q);

	assign s_tready  = (state_q == F_IDLE);
	assign job_valid = (state_q == F_PUSH);
	assign job.a     = a_q;
	assign job.b     = b_q;
	assign job.c     = c_q;
	assign job.quad  = a_mag > MAG_W'(near_zero_limit);
	assign job.last  = last_q;

endmodule

### hdl/ffms_queue.sv
module ffms_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ffms_pkg::ffms_job_t wdata,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output ffms_pkg::ffms_job_t rdata
);
	import ffms_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	ffms_job_t slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] count_q;

	assign full  = (count_q == (PTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

### hdl/ffms_back.sv
module ffms_back #(
	parameter int FRAC_BITS = ffms_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffms_pkg::ffms_job_t           job,
	input  logic                          job_empty,
	output logic                          job_pop,
	input  logic [ffms_pkg::FRAC_W-1:0]   step_fraction,
	input  logic [ffms_pkg::FRAC_W-1:0]   step_cap,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ffms_pkg::OUT_W-1:0]    m_tdata,
	output logic [0:0]                    m_tuser
);
	import ffms_pkg::*;

	localparam int KB_W   = MAG_W + FRAC_BITS;
	localparam int SQ_W   = (DISC_W + 2*FRAC_BITS + 1) / 2;
	localparam int RAD_W  = 2 * SQ_W;
	localparam int NUM_W  = ((KB_W > SQ_W) ? KB_W : SQ_W) + 1;
	localparam int DEN_W  = MAG_W + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int CNT_W  = $clog2(NUM_W + 1);
	localparam int RC_W   = FRAC_BITS + 18;
	localparam int P_W    = FRAC_W + RC_W;
	localparam logic [RC_W-1:0] ROOT_TOP = RC_W'(1) << (FRAC_BITS + 17);

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_MUL  = 4'd1;
	localparam logic [3:0] B_DISC = 4'd2;
	localparam logic [3:0] B_SQRT = 4'd3;
	localparam logic [3:0] B_NUM  = 4'd4;
	localparam logic [3:0] B_DIV  = 4'd5;
	localparam logic [3:0] B_CLIP = 4'd6;
	localparam logic [3:0] B_UPD  = 4'd7;
	localparam logic [3:0] B_PROD = 4'd8;
	localparam logic [3:0] B_EMIT = 4'd9;

	logic [3:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic last_q, bneg_q, cneg_q, cnz_q;
	logic [MAG_W-1:0] am_q, bm_q, amul_q, bmul_q;
	logic [PROD_W-1:0] bsh_q, csh_q, b2_q, ac_q;
	logic [RAD_W-1:0] rad_q;
	logic [SQ_W-1:0] sroot_q;
	logic [SQ_W+1:0] srem_q;
	logic [NUM_W-1:0] numq_q;
	logic [DEN_W-1:0] den_q, drem_q;
	logic [ROOT_W-1:0] root_q, min_q;
	logic [P_W-1:0] prod_q;
	logic found_q;
	logic out_valid_q, out_found_q;
	logic [FRAC_W-1:0] out_step_q;

	logic a_neg, b_neg0, c_neg0, b_nz, c_nz, lin_ok;
	logic [MAG_W-1:0] am_c, bm_c, cm_c;
	logic [DISC_W-1:0] b2x, ac4, d_val;
	logic disc_neg;
	logic [SQ_W+3:0] s_r2, s_trial, s_diff;
	logic s_ge;
	logic [DEN_W:0] d_r2, d_sub;
	logic d_ge;
	logic [NUM_W-1:0] kb, sx, sp;
	logic [ROOT_W-1:0] new_min;
	logic [RC_W-1:0] rc;
	logic [P_W-1:0] pshift;
	logic [FRAC_W-1:0] step_c;
	logic out_free;

	// sign handling of the popped triangle
	assign a_neg  = job.a[ACC_W-1];
	assign b_neg0 = job.b[ACC_W-1];
	assign c_neg0 = job.c[ACC_W-1];
	assign b_nz   = |job.b;
	assign c_nz   = |job.c;
	assign am_c   = mag(job.a);
	assign bm_c   = mag(job.b);
	assign cm_c   = mag(job.c);
	assign lin_ok = b_nz && c_nz && (c_neg0 ^ b_neg0);

	// discriminant
	assign b2x      = DISC_W'(b2_q);
	assign ac4      = {ac_q[PROD_W-2:0], 2'b00};
	assign disc_neg = !cneg_q && (ac4 > b2x);
	assign d_val    = cneg_q ? b2x + ac4 : b2x - ac4;

	// square root, one bit a cycle
	assign s_r2    = {2'b00, srem_q} << 2 | (SQ_W+4)'(rad_q[RAD_W-1 -: 2]);
	assign s_trial = {2'b00, sroot_q, 2'b01};
	assign s_ge    = s_r2 >= s_trial;
	assign s_diff  = s_r2 - s_trial;

	// restoring divide, one bit a cycle
	assign d_r2  = {drem_q, numq_q[NUM_W-1]};
	assign d_ge  = d_r2 >= {1'b0, den_q};
	assign d_sub = d_r2 - {1'b0, den_q};

	// numerator terms
	assign kb = NUM_W'({bm_q, {FRAC_BITS{1'b0}}});
	assign sx = NUM_W'(sroot_q);
	assign sp = sx + NUM_W'(|srem_q);

	// running minimum and emitted step
	assign new_min = (root_q < min_q) ? root_q : min_q;
	assign rc      = (min_q > ROOT_W'(ROOT_TOP)) ? ROOT_TOP : min_q[RC_W-1:0];
	assign pshift  = prod_q >> FRAC_BITS;
	assign step_c  = !found_q ? step_cap :
		(pshift < P_W'(step_cap)) ? pshift[FRAC_W-1:0] : step_cap;
	assign out_free = !out_valid_q || m_tready;

	assign job_pop = (state_q == B_IDLE) && !job_empty;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			min_q       <= ROOT_INF;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready && !(state_q == B_EMIT && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					cnt_q <= '0;
					if (!job_empty) begin
						if (job.quad) begin
							state_q <= B_MUL;
						end else if (lin_ok) begin
							state_q <= B_DIV;
						end else begin
							state_q <= B_UPD;
						end
					end
				end
				B_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAG_W-1)) begin
						state_q <= B_DISC;
					end
				end
				B_DISC: begin
					cnt_q   <= '0;
					state_q <= disc_neg ? B_UPD : B_SQRT;
				end
				B_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SQ_W-1)) begin
						state_q <= B_NUM;
					end
				end
				B_NUM: begin
					cnt_q   <= '0;
					state_q <= (bneg_q || cneg_q) ? B_DIV : B_UPD;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W-1)) begin
						state_q <= B_CLIP;
					end
				end
				B_CLIP: begin
					state_q <= B_UPD;
				end
				B_UPD: begin
					min_q   <= new_min;
					state_q <= last_q ? B_PROD : B_IDLE;
				end
				B_PROD: begin
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						min_q       <= ROOT_INF;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				last_q <= job.last;
				root_q <= ROOT_INF;
				if (job.quad) begin
					am_q   <= am_c;
					bm_q   <= bm_c;
					bneg_q <= b_nz && (b_neg0 ^ a_neg);
					cneg_q <= c_nz && (c_neg0 ^ a_neg);
					cnz_q  <= c_nz;
					amul_q <= am_c;
					bmul_q <= bm_c;
					bsh_q  <= PROD_W'(bm_c);
					csh_q  <= PROD_W'(cm_c);
					b2_q   <= '0;
					ac_q   <= '0;
				end else begin
					numq_q <= NUM_W'({cm_c, {FRAC_BITS{1'b0}}});
					den_q  <= DEN_W'(bm_c);
					drem_q <= '0;
				end
			end
			B_MUL: begin
				if (bmul_q[0]) b2_q <= b2_q + bsh_q;
				if (amul_q[0]) ac_q <= ac_q + csh_q;
				bmul_q <= bmul_q >> 1;
				amul_q <= amul_q >> 1;
				bsh_q  <= bsh_q << 1;
				csh_q  <= csh_q << 1;
			end
			B_DISC: begin
				rad_q   <= RAD_W'({d_val, {(2*FRAC_BITS){1'b0}}});
				sroot_q <= '0;
				srem_q  <= '0;
			end
			B_SQRT: begin
				srem_q  <= s_ge ? s_diff[SQ_W+1:0] : s_r2[SQ_W+1:0];
				sroot_q <= {sroot_q[SQ_W-2:0], s_ge};
				rad_q   <= rad_q << 2;
			end
			B_NUM: begin
				den_q  <= {am_q, 1'b0};
				drem_q <= '0;
				if (bneg_q && !cneg_q && cnz_q) begin
					numq_q <= kb - sp;
				end else if (bneg_q) begin
					numq_q <= kb + sx;
				end else begin
					numq_q <= sx - kb;
				end
			end
			B_DIV: begin
				drem_q <= d_ge ? d_sub[DEN_W-1:0] : d_r2[DEN_W-1:0];
				numq_q <= {numq_q[NUM_W-2:0], d_ge};
			end
			B_CLIP: begin
				root_q <= (numq_q >= NUM_W'(ROOT_INF)) ? ROOT_INF : numq_q[ROOT_W-1:0];
			end
			B_PROD: begin
				prod_q  <= P_W'(step_fraction) * P_W'(rc);
				found_q <= (min_q != ROOT_INF);
			end
			B_EMIT: begin
				if (out_free) begin
					out_step_q  <= step_c;
					out_found_q <= found_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_step_q);
	assign m_tuser  = out_found_q;

`ifndef SYNTHESIS
	a_inf_gives_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && !out_found_q |-> out_step_q == step_cap)
		else $error("no root but step differs from cap");
	a_step_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> out_step_q <= step_cap)
		else $error("step above cap");
	a_min_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_EMIT && out_free |=> min_q == ROOT_INF)
		else $error("minimum not cleared after last face");
`endif

endmodule

### sim/ffms_checker.sv
`timescale 1ns / 100ps

module ffms_checker
	import ffms_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [IN_W*N_OPS-1:0]    s_tdata,
	input  logic                     s_tlast,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_W-1:0]         m_tdata,
	input  logic [0:0]               m_tuser,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [LIM_W-1:0]         cfg_data,
	output int                       fail_count,
	output int                       pending,
	output int                       mesh_count,
	output int                       found_count
);

	localparam int FB = FRAC_BITS_DEF;

	typedef logic [255:0]        wide_t;
	typedef logic signed [255:0] swide_t;

	typedef struct {
		logic [FRAC_W-1:0] step_size;
		logic              root_found;
	} step_word_t;

	// own copy of the registers and the running minimum
	logic [FRAC_W-1:0] fraction_q;
	logic [FRAC_W-1:0] cap_q;
	logic [LIM_W-1:0]  near_zero_q;
	logic [ROOT_W-1:0] min_root;
	step_word_t        step_q[$];

	// bit by bit integer square root
	function automatic wide_t int_sqrt(input wide_t n);
		wide_t r;
		wide_t cand;
		r = '0;
		for (int i = 127; i >= 0; i--) begin
			cand = r | (wide_t'(1) << i);
			if (cand * cand <= n)
				r = cand;
		end
		return r;
	endfunction

	function automatic logic [ROOT_W-1:0] clip_root(input wide_t q);
		if (q >= wide_t'(ROOT_INF))
			return ROOT_INF;
		return q[ROOT_W-1:0];
	endfunction

	// smallest positive root of det(E + tD), scaled by 2^FB
	function automatic logic [ROOT_W-1:0] face_root(input logic [IN_W*N_OPS-1:0] w);
		swide_t v[N_OPS];
		swide_t a, b, c;
		wide_t  am, bm, cm, b2, ac4, disc, k2d, s, kb, den, num;
		for (int i = 0; i < N_OPS; i++)
			v[i] = {{(256-IN_W){w[IN_W*i+IN_W-1]}}, w[IN_W*i +: IN_W]};
		a = v[4] * v[7] - v[6] * v[5];
		c = v[0] * v[3] - v[2] * v[1];
		b = v[0] * v[7] - v[2] * v[5] + v[4] * v[3] - v[6] * v[1];
		am = (a < 0) ? wide_t'(-a) : wide_t'(a);
		if (am > wide_t'(near_zero_q)) begin
			// quadratic: make a positive first
			if (a < 0) begin
				a = -a;
				b = -b;
				c = -c;
			end
			am = wide_t'(a);
			bm = (b < 0) ? wide_t'(-b) : wide_t'(b);
			cm = (c < 0) ? wide_t'(-c) : wide_t'(c);
			b2 = bm * bm;
			ac4 = (am * cm) << 2;
			if (c < 0)
				disc = b2 + ac4;
			else begin
				if (ac4 > b2)
					return ROOT_INF;
				disc = b2 - ac4;
			end
			k2d = disc << (2 * FB);
			s = int_sqrt(k2d);
			kb = bm << FB;
			den = am << 1;
			if (b < 0 && c > 0) begin
				// smaller root: round the square root up so the quotient floors
				if (s * s != k2d)
					s = s + 1;
				num = kb - s;
			end else if (b < 0)
				num = kb + s;
			else if (c < 0)
				num = s - kb;
			else
				return ROOT_INF;
			return clip_root(num / den);
		end
		// linear
		if (b == 0)
			return ROOT_INF;
		if (b < 0) begin
			b = -b;
			c = -c;
		end
		if (c >= 0)
			return ROOT_INF;
		bm = wide_t'(b);
		num = wide_t'(-c) << FB;
		return clip_root(num / bm);
	endfunction

	function automatic step_word_t mesh_step(input logic [ROOT_W-1:0] r);
		step_word_t sw;
		logic [63:0] root;
		logic [63:0] p;
		sw.root_found = (r != ROOT_INF);
		if (!sw.root_found)
			sw.step_size = cap_q;
		else begin
			root = 64'(r);
			if (root > (64'd1 << (FB + 17)))
				root = 64'd1 << (FB + 17);
			p = (64'(fraction_q) * root) >> FB;
			sw.step_size = (p < 64'(cap_q)) ? p[FRAC_W-1:0] : cap_q;
		end
		return sw;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// watch the channels, predict and compare
	always @(posedge clk or negedge arst_n) begin
		logic [ROOT_W-1:0] r;
		step_word_t sw;
		if (!arst_n) begin
			fraction_q  <= STEP_FRACTION_RST;
			cap_q       <= STEP_CAP_RST;
			near_zero_q <= NEAR_ZERO_RST;
			min_root    = ROOT_INF;
			step_q.delete();
			pending     = 0;
			fail_count  = 0;
			mesh_count  = 0;
			found_count = 0;
		end else begin
			// result word first, so a same-edge push cannot be popped
			if (m_tvalid && m_tready) begin
				mesh_count++;
				if (step_q.size() == 0)
					report("unexpected word, step_size", 32'(m_tdata), 0);
				else begin
					sw = step_q.pop_front();
					if (m_tdata[FRAC_W-1:0] !== sw.step_size)
						report("step_size", 32'(m_tdata[FRAC_W-1:0]), 32'(sw.step_size));
					if (m_tdata[OUT_W-1:FRAC_W] !== '0)
						report("m_tdata fill", 32'(m_tdata[OUT_W-1:FRAC_W]), 0);
					if (m_tuser[0] !== sw.root_found)
						report("root_found", 32'(m_tuser[0]), 32'(sw.root_found));
				end
			end
			if (s_tvalid && s_tready) begin
				r = face_root(s_tdata);
				if (r < min_root)
					min_root = r;
				if (s_tlast) begin
					sw = mesh_step(min_root);
					if (sw.root_found)
						found_count++;
					step_q.push_back(sw);
					min_root = ROOT_INF;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STEP_FRACTION: fraction_q <= cfg_data[FRAC_W-1:0];
					REG_STEP_CAP:      cap_q <= cfg_data[FRAC_W-1:0];
					REG_NEAR_ZERO:     near_zero_q <= cfg_data;
					default: ;
				endcase
			end
			pending = step_q.size();
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import ffms_pkg::*;

	localparam int  PHASES     = 8;
	localparam int  PHASE_FACES = 250;
	localparam int  SETTLE     = 400;
	localparam longint LIMIT   = 4000000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W*N_OPS-1:0] s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [LIM_W-1:0]      cfg_data;

	int     fail_count, pending, mesh_count, found_count;
	int     faces_sent;
	int     burst_left;
	int     stall_pct;
	logic   hold_off;
	longint cycles = 0;

	flip_free_max_step_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	ffms_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.mesh_count (mesh_count),
		.found_count(found_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: stall rate changes now and then, zero included
	initial begin
		stall_pct = 0;
		forever begin
			repeat (600) @(posedge clk);
			stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 80);
		end
	end

	always @(negedge clk)
		m_tready <= hold_off ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);

	// long receiver hold-off while the sender keeps offering
	initial begin
		hold_off = 1'b0;
		wait (faces_sent >= 400);
		hold_off = 1'b1;
		repeat (5000) @(posedge clk);
		hold_off = 1'b0;
	end

	// one triangle word, bursts with random gaps
	task automatic send_face(input logic [IN_W*N_OPS-1:0] w, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		faces_sent++;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for every step word, then let a root in flight drain
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [31:0] rnd_fix(input int sh);
		int x;
		x = $urandom;
		return 32'(x >>> (31 - sh));
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'h1;
			4: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IN_W*N_OPS-1:0] pack_face(input logic [31:0] f[N_OPS]);
		logic [IN_W*N_OPS-1:0] w;
		for (int i = 0; i < N_OPS; i++)
			w[IN_W*i +: IN_W] = f[i];
		return w;
	endfunction

	// mostly plausible layouts and moves, some noise
	function automatic logic [IN_W*N_OPS-1:0] rand_face();
		logic [31:0] f[N_OPS];
		int kind, es, ds;
		kind = $urandom_range(0, 9);
		es = $urandom_range(4, 30);
		ds = $urandom_range(2, 30);
		for (int i = 0; i < 4; i++) begin
			case (kind)
				0: begin
					f[i] = $urandom;
					f[i+4] = $urandom;
				end
				1: begin
					f[i] = pick_extreme();
					f[i+4] = pick_extreme();
				end
				2: begin
					// move nearly collapses the triangle
					f[i] = rnd_fix(es);
					f[i+4] = -f[i] + rnd_fix($urandom_range(0, 8));
				end
				default: begin
					f[i] = rnd_fix(es);
					f[i+4] = rnd_fix(ds);
				end
			endcase
		end
		return pack_face(f);
	endfunction

	// directed triangles, each its own mesh unless noted
	task automatic directed_part();
		logic [31:0] f[N_OPS];
		localparam logic [31:0] ONE = 32'h0001_0000;
		// zero triangle: infinite minimum
		f = '{default: 32'h0};
		send_face(pack_face(f), 1'b1);
		// double root at one
		f = '{ONE, 0, 0, ONE, -ONE, 0, 0, -ONE};
		send_face(pack_face(f), 1'b1);
		// no move: linear with b zero
		f = '{ONE, 0, 0, ONE, 0, 0, 0, 0};
		send_face(pack_face(f), 1'b1);
		// linear root at one
		f = '{ONE, 0, 0, ONE, -ONE, 0, 0, 0};
		send_face(pack_face(f), 1'b1);
		// rotation: negative discriminant
		f = '{ONE, 0, 0, ONE, 0, ONE, -ONE, 0};
		send_face(pack_face(f), 1'b1);
		// growing triangle: roots not positive
		f = '{ONE, 0, 0, ONE, ONE, 0, 0, ONE};
		send_face(pack_face(f), 1'b1);
		// root beyond the root word saturates
		f = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0};
		send_face(pack_face(f), 1'b1);
		// huge finite root, then smaller ones in the same mesh
		f = '{32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0};
		send_face(pack_face(f), 1'b1);
		send_face(pack_face(f), 1'b0);
		f = '{ONE, 0, 0, ONE, -ONE, 0, 0, -ONE};
		send_face(pack_face(f), 1'b0);
		f = '{ONE, 0, 0, ONE, -(ONE <<< 2), 0, 0, 0};
		send_face(pack_face(f), 1'b1);
		// inverted triangle: c negative
		f = '{0, ONE, ONE, 0, ONE, 0, 0, ONE};
		send_face(pack_face(f), 1'b1);
		// field extremes
		f = '{default: 32'h8000_0000};
		send_face(pack_face(f), 1'b1);
		f = '{default: 32'h7FFF_FFFF};
		send_face(pack_face(f), 1'b1);
		f = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
		send_face(pack_face(f), 1'b1);
		f = '{default: 32'hFFFF_FFFF};
		send_face(pack_face(f), 1'b1);
	endtask

	task automatic set_phase(input int ph);
		logic [31:0] fr, cp, nz;
		case (ph)
			0: begin fr = 0;      cp = 65536;  nz = 0;             end
			1: begin fr = 65536;  cp = 0;      nz = 32'hFFFF_FFFF; end
			2: begin fr = 131071; cp = 131071; nz = 0;             end
			3: begin fr = 1;      cp = 1;      nz = 32'h0010_0000; end
			4: begin fr = 32768;  cp = 40000;  nz = $urandom;      end
			5: begin fr = $urandom_range(0, 131071); cp = $urandom_range(0, 131071);
				nz = $urandom_range(0, 65535); end
			6: begin fr = 65535;  cp = 65536;  nz = 32'hFFFF;      end
			default: begin fr = 52429; cp = 65536; nz = 0;         end
		endcase
		cfg_write(REG_STEP_FRACTION, fr);
		cfg_write(REG_STEP_CAP, cp);
		cfg_write(REG_NEAR_ZERO, nz);
	endtask

	// stimulus and verdict
	initial begin
		int n, len;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_STEP_FRACTION;
		cfg_data   = '0;
		faces_sent = 0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_part();

		for (int ph = 0; ph < PHASES; ph++) begin
			// sender pauses until every step word has come
			drain();
			set_phase(ph);
			n = 0;
			while (n < PHASE_FACES) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_face(rand_face(), k == len - 1);
				n += len;
			end
		end

		drain();
		$display("%0d triangles in %0d meshes over %0d register settings",
			faces_sent, mesh_count, PHASES + 1);
		$display("%0d meshes had a finite flip time", found_count);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
